### hw/rtl/fas_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fas_pkg
// Shared types, codes and constants of the fused approach steering step.
// ----------------------------------------------------------------------------
package fas_pkg;

   // field widths
   localparam int DIST_W   = 13;
   localparam int ANGLE_W  = 15;
   localparam int TIME_W   = 32;
   localparam int LEAD_W   = 20;
   localparam int BAND_W   = 14;
   localparam int BYTE_W   = 8;
   localparam int PWM_W    = 10;
   localparam int IR_W     = 3;
   localparam int SECTOR_W = 2;
   localparam int CSR_DATA_W = 20;

   // pwm limits
   localparam logic [PWM_W-1:0] PWM_MIN = 10'd800;
   localparam logic [PWM_W-1:0] PWM_MAX = 10'd999;

   // angle wrap points, 1/64 degree
   localparam logic [ANGLE_W-1:0] HALF_TURN = 15'd11520;
   localparam logic [ANGLE_W:0]   FULL_TURN = 16'd23040;

   // register reset values
   localparam logic [DIST_W-1:0] RST_STOP_DISTANCE  = 13'd80;
   localparam logic [LEAD_W-1:0] RST_LEAD_TIME_US   = 20'd300000;
   localparam logic [BAND_W-1:0] RST_ANGLE_DEADBAND = 14'd320;
   localparam logic [BYTE_W-1:0] RST_STEER_GAIN     = 8'd28;
   localparam logic [BYTE_W-1:0] RST_MAX_STEER      = 8'd90;
   localparam logic [BYTE_W-1:0] RST_IR_STEER       = 8'd90;
   localparam logic [PWM_W-1:0]  RST_BASE_PWM       = 10'd910;
   localparam logic [DIST_W-1:0] RST_CENTER_BAND    = 13'd64;

   // register indexes
   typedef enum logic [2:0] {
      REG_STOP_DISTANCE  = 3'd0,
      REG_LEAD_TIME_US   = 3'd1,
      REG_ANGLE_DEADBAND = 3'd2,
      REG_STEER_GAIN     = 3'd3,
      REG_MAX_STEER      = 3'd4,
      REG_IR_STEER       = 3'd5,
      REG_BASE_PWM       = 3'd6,
      REG_CENTER_BAND    = 3'd7
   } reg_index_type;

   // ir sector codes
   localparam logic [IR_W-1:0] IR_NONE   = 3'd0;
   localparam logic [IR_W-1:0] IR_LEFT   = 3'd1;
   localparam logic [IR_W-1:0] IR_RIGHT  = 3'd2;
   localparam logic [IR_W-1:0] IR_CENTER = 3'd3;
   localparam logic [IR_W-1:0] IR_WIDE   = 3'd4;

   // reported sector codes
   localparam logic [SECTOR_W-1:0] SEC_NONE   = 2'd0;
   localparam logic [SECTOR_W-1:0] SEC_LEFT   = 2'd1;
   localparam logic [SECTOR_W-1:0] SEC_CENTER = 2'd2;
   localparam logic [SECTOR_W-1:0] SEC_RIGHT  = 2'd3;

   typedef struct packed {
      logic [DIST_W-1:0] stop_distance;
      logic [LEAD_W-1:0] lead_time_us;
      logic [BAND_W-1:0] angle_deadband;
      logic [BYTE_W-1:0] steer_gain;
      logic [BYTE_W-1:0] max_steer;
      logic [BYTE_W-1:0] ir_steer;
      logic [PWM_W-1:0]  base_pwm;
      logic [DIST_W-1:0] center_band;
   } cfg_type;

   typedef struct packed {
      logic               left_valid;
      logic [DIST_W-1:0]  left_distance;
      logic               right_valid;
      logic [DIST_W-1:0]  right_distance;
      logic [IR_W-1:0]    ir_sector;
      logic               lidar_valid;
      logic [ANGLE_W-1:0] lidar_angle;
      logic [TIME_W-1:0]  timestamp_us;
   } req_type;

   typedef struct packed {
      logic [PWM_W-1:0]    left_pwm;
      logic [PWM_W-1:0]    right_pwm;
      logic                target_reached;
      logic [SECTOR_W-1:0] sector_code;
   } rsp_type;

endpackage

### hw/rtl/fas_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fas_req_if / fas_rsp_if
// Valid/ready channels for requests and results of the steering step.
// ----------------------------------------------------------------------------
interface fas_req_if;
   logic             valid;
   logic             ready;
   fas_pkg::req_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface fas_rsp_if;
   logic             valid;
   logic             ready;
   fas_pkg::rsp_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

### hw/rtl/fas_stop.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fas_stop
// Stop decision from the nearest ultrasonic distance, with closing-speed
// prediction kept as a cross-multiplied compare, and the last-sample state.
// ----------------------------------------------------------------------------
module fas_stop (
   input  logic             clock,
   input  logic             reset,
   input  fas_pkg::req_type req,
   input  fas_pkg::cfg_type cfg,
   input  logic             commit,
   output logic             reached
);
   import fas_pkg::*;

   logic [DIST_W-1:0]        last_distance_ff, last_distance_in;
   logic [TIME_W-1:0]        last_time_ff, last_time_in;
   logic                     have_last_ff, have_last_in;

   logic                     any_valid;
   logic [DIST_W-1:0]        cur;
   logic                     near;
   logic [TIME_W-1:0]        elapsed;
   logic                     predict_ok;
   logic [DIST_W-1:0]        gap;
   logic [DIST_W-1:0]        closing;
   logic [DIST_W+TIME_W-1:0] lhs;
   logic [DIST_W+LEAD_W-1:0] rhs;

   // nearest valid distance
   always_comb begin
      any_valid = req.left_valid | req.right_valid;
      if (req.left_valid && req.right_valid) begin
         cur = (req.left_distance < req.right_distance) ? req.left_distance
                                                         : req.right_distance;
      end else if (req.left_valid) begin
         cur = req.left_distance;
      end else begin
         cur = req.right_distance;
      end
   end

   // direct threshold and predicted threshold
   assign near       = (cur <= cfg.stop_distance);
   assign elapsed    = req.timestamp_us - last_time_ff;
   assign predict_ok = have_last_ff && (cur < last_distance_ff) && (elapsed != '0);
   assign gap        = cur - cfg.stop_distance;
   assign closing    = last_distance_ff - cur;
   assign lhs        = gap * elapsed;
   assign rhs        = closing * cfg.lead_time_us;

   assign reached = any_valid &&
                    (near || (predict_ok && (lhs <= (DIST_W+TIME_W)'(rhs))));

   // state follows each non-stopping tick with a distance
   always_comb begin
      last_distance_in = last_distance_ff;
      last_time_in     = last_time_ff;
      have_last_in     = have_last_ff;
      if (commit && any_valid && !reached) begin
         last_distance_in = cur;
         last_time_in     = req.timestamp_us;
         have_last_in     = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_distance_ff <= '0;
         last_time_ff     <= '0;
         have_last_ff     <= 1'b0;
      end else begin
         last_distance_ff <= last_distance_in;
         last_time_ff     <= last_time_in;
         have_last_ff     <= have_last_in;
      end
   end

endmodule

### hw/rtl/fas_steer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fas_steer
// Sector choice and differential drive PWM from lidar angle and IR sector.
// ----------------------------------------------------------------------------
module fas_steer (
   input  fas_pkg::req_type req,
   input  fas_pkg::cfg_type cfg,
   input  logic             reached,
   output fas_pkg::rsp_type rsp
);
   import fas_pkg::*;

   localparam int SUM_W  = PWM_W + 2;
   localparam int PROD_W = BAND_W + BYTE_W;

   logic [IR_W-1:0]        ir;
   logic signed [ANGLE_W:0] ang;
   logic                   ang_neg;
   logic [ANGLE_W:0]       ang_abs;
   logic [BAND_W-1:0]      mag;
   logic                   outside;
   logic [PROD_W-1:0]      prod;
   logic [PROD_W-10:0]     quot;
   logic [BYTE_W-1:0]      lim;
   logic signed [SUM_W-1:0] corr;
   logic signed [SUM_W-1:0] base_s;
   logic signed [SUM_W-1:0] ir_s;
   logic signed [SUM_W-1:0] lp;
   logic signed [SUM_W-1:0] rp;
   logic [DIST_W-1:0]      diff;
   logic [SECTOR_W-1:0]    sector;

   function automatic logic [PWM_W-1:0] clamp_pwm(input logic signed [SUM_W-1:0] v);
      logic signed [SUM_W-1:0] lo;
      logic signed [SUM_W-1:0] hi;
      lo = signed'(SUM_W'(PWM_MIN));
      hi = signed'(SUM_W'(PWM_MAX));
      if (v < lo) begin
         clamp_pwm = PWM_MIN;
      end else if (v > hi) begin
         clamp_pwm = PWM_MAX;
      end else begin
         clamp_pwm = v[PWM_W-1:0];
      end
   endfunction

   // unknown ir codes count as none
   assign ir = (req.ir_sector > IR_WIDE) ? IR_NONE : req.ir_sector;

   // angle wrapped to (-180, +180] degrees
   always_comb begin
      if (req.lidar_angle > HALF_TURN) begin
         ang = signed'({1'b0, req.lidar_angle}) - signed'(FULL_TURN);
      end else begin
         ang = signed'({1'b0, req.lidar_angle});
      end
      ang_neg = ang[ANGLE_W];
      ang_abs = ang_neg ? (ANGLE_W+1)'(-ang) : ang;
      mag     = ang_abs[BAND_W-1:0];
      outside = req.lidar_valid && (mag > cfg.angle_deadband);
   end

   // proportional correction, truncated toward zero and limited
   assign prod = mag * cfg.steer_gain;
   assign quot = prod[PROD_W-1:9];
   assign lim  = (quot > (PROD_W-9)'(cfg.max_steer)) ? cfg.max_steer : quot[BYTE_W-1:0];
   assign corr = ang_neg ? -signed'(SUM_W'(lim)) : signed'(SUM_W'(lim));

   // drive sums
   always_comb begin
      base_s = signed'(SUM_W'(cfg.base_pwm));
      ir_s   = signed'(SUM_W'(cfg.ir_steer));
      lp     = base_s;
      rp     = base_s;
      if (outside) begin
         lp = lp + corr;
         rp = rp - corr;
      end
      if (ir == IR_LEFT) begin
         lp = lp - ir_s;
         rp = rp + ir_s;
      end else if (ir == IR_RIGHT) begin
         lp = lp + ir_s;
         rp = rp - ir_s;
      end
   end

   // sector: ir first, then lidar, then ultrasonic pair, then a single ultrasonic side
   always_comb begin
      diff = (req.left_distance > req.right_distance)
             ? req.left_distance - req.right_distance
             : req.right_distance - req.left_distance;
      if (ir == IR_LEFT) begin
         sector = SEC_LEFT;
      end else if (ir == IR_RIGHT) begin
         sector = SEC_RIGHT;
      end else if (ir != IR_NONE) begin
         sector = SEC_CENTER;
      end else if (req.lidar_valid) begin
         if (!outside) begin
            sector = SEC_CENTER;
         end else begin
            sector = ang_neg ? SEC_LEFT : SEC_RIGHT;
         end
      end else if (req.left_valid && req.right_valid) begin
         if (diff <= cfg.center_band) begin
            sector = SEC_CENTER;
         end else begin
            sector = (req.left_distance < req.right_distance) ? SEC_LEFT : SEC_RIGHT;
         end
      end else if (req.left_valid) begin
         sector = SEC_LEFT;
      end else if (req.right_valid) begin
         sector = SEC_RIGHT;
      end else begin
         sector = SEC_NONE;
      end
   end

   // result assembly
   always_comb begin
      rsp.target_reached = reached;
      rsp.sector_code    = sector;
      if (reached) begin
         rsp.left_pwm  = PWM_MIN;
         rsp.right_pwm = PWM_MIN;
      end else begin
         rsp.left_pwm  = clamp_pwm(lp);
         rsp.right_pwm = clamp_pwm(rp);
      end
   end

endmodule

### hw/rtl/fused_approach_steering_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fused_approach_steering_step
// One control tick of fused sensor readings in, drive PWMs, stop flag and
// object sector out.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake          | payload
//  req_if   | in        | valid/ready        | fas_pkg::req_type
//  rsp_if   | out       | valid/ready        | fas_pkg::rsp_type
//  csr_*    | in        | csr_we, no ready   | csr_index, csr_wdata
//
// One request per cycle while the result channel is not stalled; a result
// passes the request register, then the result register, before it is
// valid on the result channel.
// The stop unit's 13x32 multiply and compare lie on the combinational path between the two registers.
// Synchronous reset clears valids and the last-sample state and loads the configuration reset values.
// A stalled result holds in the result register while one more request waits
// in the request register; ready falls only when both are full.
// ----------------------------------------------------------------------------
module fused_approach_steering_step (
   input  logic                              clock,
   input  logic                              reset,
   fas_req_if.sink                           req_if,
   fas_rsp_if.source                         rsp_if,
   input  logic                              csr_we,
   input  fas_pkg::reg_index_type            csr_index,
   input  logic [fas_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import fas_pkg::*;

   cfg_type cfg_ff, cfg_in;
   logic    req_valid_ff, req_valid_in;
   req_type req_data_ff, req_data_in;
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff, rsp_data_in;
   logic    advance;
   logic    reached;
   rsp_type result;

   // configuration writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            REG_STOP_DISTANCE:  cfg_in.stop_distance  = csr_wdata[DIST_W-1:0];
            REG_LEAD_TIME_US:   cfg_in.lead_time_us   = csr_wdata[LEAD_W-1:0];
            REG_ANGLE_DEADBAND: cfg_in.angle_deadband = csr_wdata[BAND_W-1:0];
            REG_STEER_GAIN:     cfg_in.steer_gain     = csr_wdata[BYTE_W-1:0];
            REG_MAX_STEER:      cfg_in.max_steer      = csr_wdata[BYTE_W-1:0];
            REG_IR_STEER:       cfg_in.ir_steer       = csr_wdata[BYTE_W-1:0];
            REG_BASE_PWM:       cfg_in.base_pwm       = csr_wdata[PWM_W-1:0];
            REG_CENTER_BAND:    cfg_in.center_band    = csr_wdata[DIST_W-1:0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   // pipeline flow
   assign advance      = req_valid_ff && (!rsp_valid_ff || rsp_if.ready);
   assign req_if.ready = !req_valid_ff || advance;

   always_comb begin
      req_valid_in = req_valid_ff;
      req_data_in  = req_data_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (advance) begin
         req_valid_in = 1'b0;
         rsp_valid_in = 1'b1;
         rsp_data_in  = result;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (req_if.valid && req_if.ready) begin
         req_valid_in = 1'b1;
         req_data_in  = req_if.payload;
      end
   end

   // stop decision and last-sample state
   fas_stop u_stop (
      .clock   (clock),
      .reset   (reset),
      .req     (req_data_ff),
      .cfg     (cfg_ff),
      .commit  (advance),
      .reached (reached)
   );

   // sector and drive outputs
   fas_steer u_steer (
      .req     (req_data_ff),
      .cfg     (cfg_ff),
      .reached (reached),
      .rsp     (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.stop_distance  <= RST_STOP_DISTANCE;
         cfg_ff.lead_time_us   <= RST_LEAD_TIME_US;
         cfg_ff.angle_deadband <= RST_ANGLE_DEADBAND;
         cfg_ff.steer_gain     <= RST_STEER_GAIN;
         cfg_ff.max_steer      <= RST_MAX_STEER;
         cfg_ff.ir_steer       <= RST_IR_STEER;
         cfg_ff.base_pwm       <= RST_BASE_PWM;
         cfg_ff.center_band    <= RST_CENTER_BAND;
         req_valid_ff          <= 1'b0;
         rsp_valid_ff          <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_data_ff <= req_data_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_if.valid   = rsp_valid_ff;
   assign rsp_if.payload = rsp_data_ff;

endmodule
